// File: rtl/xcl_pkg.sv
`default_nettype none
package xcl_pkg;

  localparam int ID_W     = 64;
  localparam int HANDLE_W = 16;
  localparam int RANK_W   = 3;
  localparam int MODE_W   = 2;

  localparam int LIST_SIZE_DEF   = 8;
  localparam int ID_BITS_DEF     = 64;
  localparam int HANDLE_BITS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFFER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd2;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage
`default_nettype wire

// File: rtl/xcl_ram.sv
`default_nettype none
module xcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/xcl_dist_cmp.sv
`default_nettype none
module xcl_dist_cmp import xcl_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  wire logic [ID_BITS-1:0] target,
  input  wire logic [ID_BITS-1:0] cand_id,
  input  wire logic [ID_BITS-1:0] held_id,
  output cmp_res_t                res
);

  logic [ID_BITS-1:0] cand_dist;
  logic [ID_BITS-1:0] held_dist;

  assign cand_dist = cand_id ^ target;
  assign held_dist = held_id ^ target;
  assign res.eq    = (cand_id == held_id);
  assign res.lt    = (cand_dist < held_dist);

endmodule
`default_nettype wire

// File: rtl/xor_closest_k_list.sv
// channel  | handshake              | payload
// ---------+------------------------+--------------------------------------------
// in       | start / busy           | in_mode, in_node_id, in_node_handle, in_node_good
// out      | out_valid (1 cycle)    | out_entry_id, out_entry_handle, out_entry_rank,
//          |                        | out_entry_valid, out_last
// cfg      | cfg_valid / cfg_ready  | cfg_data (target id)
//
// clear and ignored requests need no further work; an empty drain gives one result.
// a good offer reads and compares the held entries in order; a duplicate ends there,
// otherwise the entries from its place on are moved down one by one and it is written
// in; an offer that falls past the end of a full list is dropped. a drain reads the
// entries out in order. the pace is set by the single read port of the entry ram
// (registered read) and the one shared distance compare.
// reset is synchronous and clears the count, so no ram clearing pass is needed.
// results cannot be stalled; busy is high while a request is in work.
`default_nettype none
module xor_closest_k_list import xcl_pkg::*; #(
  parameter int LIST_SIZE   = LIST_SIZE_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [ID_W-1:0]     in_node_id,
  input  wire logic [HANDLE_W-1:0] in_node_handle,
  input  wire logic                in_node_good,
  output logic                     out_valid,
  output logic [ID_W-1:0]          out_entry_id,
  output logic [HANDLE_W-1:0]      out_entry_handle,
  output logic [RANK_W-1:0]        out_entry_rank,
  output logic                     out_entry_valid,
  output logic                     out_last,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [ID_W-1:0]     cfg_data
);

  localparam int AW      = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam int CW      = $clog2(LIST_SIZE + 1);
  localparam int HW      = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int ENTRY_W = ID_BITS + HW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS,
    S_DRAIN_RD
  } state_t;

  state_t             state_r;
  logic [ID_BITS-1:0] target_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      pos_r;
  logic [AW-1:0]      k_r;
  logic [ID_BITS-1:0] nid_r;
  logic [HW-1:0]      nhnd_r;
  logic               drain_out_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_BITS-1:0] rd_id;
  logic [HW-1:0]      rd_hnd;
  cmp_res_t           cmp_res;
  logic [CW-1:0]      new_cnt;
  logic               accept;

  assign busy      = (state_r != S_IDLE) || drain_out_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign rd_hnd    = ram_rdata[HW-1:0];
  assign rd_id     = ram_rdata[HW +: ID_BITS];
  assign new_cnt   = (count_r < CW'(LIST_SIZE)) ? count_r + CW'(1) : count_r;

  xcl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LIST_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  xcl_dist_cmp #(
    .ID_BITS (ID_BITS)
  ) u_cmp (
    .target  (target_r),
    .cand_id (nid_r),
    .held_id (rd_id),
    .res     (cmp_res)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_r;
    ram_wdata = ram_rdata;
    ram_raddr = pos_r[AW-1:0];
    case (state_r)
      S_SHIFT_RD: begin
        ram_raddr = k_r - AW'(1);
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = {nid_r, nhnd_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      target_r    <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      out_valid   <= 1'b0;
      drain_out_r <= 1'b0;
    end else begin
      out_valid   <= 1'b0;
      drain_out_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_data[ID_BITS-1:0];
      end
      case (state_r)
        S_IDLE: begin
          if (drain_out_r) begin
            out_valid        <= 1'b1;
            out_entry_id     <= ID_W'(rd_id);
            out_entry_handle <= HANDLE_W'(rd_hnd);
            out_entry_rank   <= RANK_W'(pos_r);
            out_entry_valid  <= 1'b1;
            out_last         <= (pos_r + CW'(1) == count_r);
            if (pos_r + CW'(1) != count_r) begin
              pos_r   <= pos_r + CW'(1);
              state_r <= S_DRAIN_RD;
            end
          end else if (accept) begin
            case (in_mode)
              MODE_CLEAR: begin
                count_r <= '0;
              end
              MODE_OFFER: begin
                if (in_node_good) begin
                  nid_r   <= in_node_id[ID_BITS-1:0];
                  nhnd_r  <= in_node_handle[HW-1:0];
                  pos_r   <= '0;
                  state_r <= S_SCAN_RD;
                end
              end
              MODE_DRAIN: begin
                pos_r <= '0;
                if (count_r == '0) begin
                  out_valid        <= 1'b1;
                  out_entry_id     <= '0;
                  out_entry_handle <= '0;
                  out_entry_rank   <= '0;
                  out_entry_valid  <= 1'b0;
                  out_last         <= 1'b1;
                end else begin
                  state_r <= S_DRAIN_RD;
                end
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          if (pos_r == count_r) begin
            state_r <= S_PLACE;
          end else begin
            state_r <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (cmp_res.eq) begin
            state_r <= S_IDLE;
          end else if (cmp_res.lt) begin
            state_r <= S_PLACE;
          end else begin
            pos_r   <= pos_r + CW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_PLACE: begin
          if (pos_r == CW'(LIST_SIZE)) begin
            state_r <= S_IDLE;
          end else begin
            count_r <= new_cnt;
            k_r     <= AW'(new_cnt - CW'(1));
            if ((new_cnt - CW'(1)) > pos_r) begin
              state_r <= S_SHIFT_RD;
            end else begin
              state_r <= S_INS;
            end
          end
        end
        S_SHIFT_RD: begin
          state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (CW'(k_r) > pos_r + CW'(1)) begin
            k_r     <= k_r - AW'(1);
            state_r <= S_SHIFT_RD;
          end else begin
            state_r <= S_INS;
          end
        end
        S_INS: begin
          state_r <= S_IDLE;
        end
        S_DRAIN_RD: begin
          drain_out_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // the list never holds more than its size
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(LIST_SIZE))
    else $error("entry count above list size");

  // a good offer keeps the block busy for the scan
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == MODE_OFFER) && in_node_good |=> busy)
    else $error("offer request not taken into work");

  // a drain result that is not the last is followed by more of the drain
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid && !out_last |-> busy)
    else $error("drain stopped before its last result");

  // a held entry always has a nonzero count behind it
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> count_r != '0)
    else $error("entry result from an empty list");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
  import xcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = LIST_SIZE_DEF;
  localparam int SETTLE_CYCLES = 4 * LIST_DEPTH + 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [RANK_W-1:0]   rank;
    logic                valid;
    logic                last;
  } list_entry_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic                good;
  } node_req_t;

  class closest_list_tracker;
    logic [ID_W-1:0]     target;
    logic [ID_W-1:0]     held_id[LIST_DEPTH];
    logic [HANDLE_W-1:0] held_handle[LIST_DEPTH];
    int                  held_count;
    list_entry_t         due_entries[$];
    int                  errors;
    int                  n_offers;
    int                  n_drains;
    int                  n_clears;
    int                  n_entries;
    int                  n_full_drains;

    function new();
      target = '0;
      held_count = 0;
      errors = 0;
      n_offers = 0;
      n_drains = 0;
      n_clears = 0;
      n_entries = 0;
      n_full_drains = 0;
    endfunction

    function void set_target(logic [ID_W-1:0] value);
      target = value;
    endfunction

    function void insert_node(logic [ID_W-1:0] id, logic [HANDLE_W-1:0] handle);
      int pos;
      logic [ID_W-1:0] cand_dist;
      pos = 0;
      cand_dist = id ^ target;
      while (pos < held_count) begin
        if (held_id[pos] == id) return;
        if (cand_dist < (held_id[pos] ^ target)) break;
        pos++;
      end
      if (pos >= LIST_DEPTH) return;
      if (held_count < LIST_DEPTH) held_count++;
      for (int k = held_count - 1; k > pos; k--) begin
        held_id[k] = held_id[k-1];
        held_handle[k] = held_handle[k-1];
      end
      held_id[pos] = id;
      held_handle[pos] = handle;
    endfunction

    function void note_request(node_req_t req);
      list_entry_t e;
      case (req.mode)
        MODE_CLEAR: begin
          held_count = 0;
          n_clears++;
        end
        MODE_OFFER: begin
          n_offers++;
          if (req.good) insert_node(req.id, req.handle);
        end
        MODE_DRAIN: begin
          n_drains++;
          if (held_count == LIST_DEPTH) n_full_drains++;
          if (held_count == 0) begin
            e = '{id: '0, handle: '0, rank: '0, valid: 1'b0, last: 1'b1};
            due_entries.push_back(e);
          end else begin
            for (int k = 0; k < held_count; k++) begin
              e.id = held_id[k];
              e.handle = held_handle[k];
              e.rank = k[RANK_W-1:0];
              e.valid = 1'b1;
              e.last = (k + 1 == held_count);
              due_entries.push_back(e);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [ID_W-1:0] exp_v, logic [ID_W-1:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_entry(list_entry_t got);
      list_entry_t exp_e;
      n_entries++;
      if (due_entries.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual id %h handle %h rank %0d",
                 $time, got.id, got.handle, got.rank);
        return;
      end
      exp_e = due_entries.pop_front();
      compare_field("entry_id", exp_e.id, got.id);
      compare_field("entry_handle", ID_W'(exp_e.handle), ID_W'(got.handle));
      compare_field("entry_rank", ID_W'(exp_e.rank), ID_W'(got.rank));
      compare_field("entry_valid", ID_W'(exp_e.valid), ID_W'(got.valid));
      compare_field("last", ID_W'(exp_e.last), ID_W'(got.last));
    endfunction

    function int pending();
      return due_entries.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   in_mode;
  logic [ID_W-1:0]     in_node_id;
  logic [HANDLE_W-1:0] in_node_handle;
  logic                in_node_good;
  logic                out_valid;
  logic [ID_W-1:0]     out_entry_id;
  logic [HANDLE_W-1:0] out_entry_handle;
  logic [RANK_W-1:0]   out_entry_rank;
  logic                out_entry_valid;
  logic                out_last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ID_W-1:0]     cfg_data;

  closest_list_tracker tracker = new();
  logic [ID_W-1:0] id_pool[16];
  int              pool_fill = 0;
  int              n_targets = 1;

  xor_closest_k_list uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_node_id       (in_node_id),
    .in_node_handle   (in_node_handle),
    .in_node_good     (in_node_good),
    .out_valid        (out_valid),
    .out_entry_id     (out_entry_id),
    .out_entry_handle (out_entry_handle),
    .out_entry_rank   (out_entry_rank),
    .out_entry_valid  (out_entry_valid),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        tracker.check_entry('{out_entry_id, out_entry_handle, out_entry_rank,
                              out_entry_valid, out_last});
      if (start && !busy)
        tracker.note_request('{in_mode, in_node_id, in_node_handle, in_node_good});
      if (cfg_valid && cfg_ready)
        tracker.set_target(cfg_data);
    end
  end

  function automatic node_req_t make_req(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                         logic [HANDLE_W-1:0] handle, logic good);
    node_req_t r;
    r.mode = mode;
    r.id = id;
    r.handle = handle;
    r.good = good;
    return r;
  endfunction

  function automatic node_req_t random_req();
    node_req_t r;
    int pick;
    r.id = {$urandom, $urandom};
    r.handle = HANDLE_W'($urandom);
    r.good = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 4) r.mode = MODE_CLEAR;
    else if (pick < 18) r.mode = MODE_DRAIN;
    else if (pick < 21) r.mode = MODE_UNUSED;
    else begin
      r.mode = MODE_OFFER;
      pick = $urandom_range(0, 9);
      if (pick < 4)
        r.id = tracker.target ^ ({$urandom, $urandom} >> $urandom_range(0, 63));
      else if (pick < 6 && pool_fill > 0)
        r.id = id_pool[$urandom_range(0, pool_fill - 1)];
      id_pool[$urandom_range(0, 15)] = r.id;
      if (pool_fill < 16) begin
        id_pool[pool_fill] = r.id;
        pool_fill++;
      end
    end
    return r;
  endfunction

  task automatic send_req(node_req_t r);
    start <= 1'b1;
    in_mode <= r.mode;
    in_node_id <= r.id;
    in_node_handle <= r.handle;
    in_node_good <= r.good;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_quiet();
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(logic [ID_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_targets++;
  endtask

  task automatic run_random(int n);
    node_req_t r;
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        r = random_req();
        send_req(r);
        if (!(r.mode == MODE_UNUSED || (r.mode == MODE_OFFER && !r.good))) sent++;
      end
      start <= 1'b0;
      if ($urandom_range(0, 19) == 0) wait_quiet();
      else if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_CLEAR;
    in_node_id = '0;
    in_node_handle = '0;
    in_node_good = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, ignored requests, extremes, duplicates, overflow
    send_req(make_req(MODE_DRAIN, '0, '0, 1'b0));
    send_req(make_req(MODE_UNUSED, '1, '1, 1'b1));
    send_req(make_req(MODE_OFFER, '1, '1, 1'b1));
    send_req(make_req(MODE_OFFER, '0, '0, 1'b1));
    send_req(make_req(MODE_OFFER, 64'd5, 16'h1234, 1'b0));
    send_req(make_req(MODE_OFFER, '1, 16'h0bad, 1'b1));
    send_req(make_req(MODE_DRAIN, '0, '0, 1'b0));
    send_req(make_req(MODE_CLEAR, '0, '0, 1'b0));
    send_req(make_req(MODE_DRAIN, '0, '0, 1'b0));
    for (int i = 1; i <= LIST_DEPTH + 2; i++)
      send_req(make_req(MODE_OFFER, ID_W'(i), HANDLE_W'(16'ha000 + i), 1'b1));
    send_req(make_req(MODE_OFFER, '0, 16'h5555, 1'b1));
    send_req(make_req(MODE_OFFER, '0, 16'haaaa, 1'b1));
    send_req(make_req(MODE_DRAIN, '0, '0, 1'b0));
    start <= 1'b0;
    wait_quiet();

    // no clear between targets: held order follows the old target
    foreach (id_pool[i]) id_pool[i] = '0;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_target('1);
        1: write_target({$urandom, $urandom});
        2: write_target('0);
        3: write_target({1'b1, {(ID_W-1){1'b0}}});
        default: write_target({$urandom, $urandom});
      endcase
      run_random(80);
      wait_quiet();
    end

    $display("covered %0d offers, %0d drains (%0d on a full list), %0d clears, %0d targets",
             tracker.n_offers, tracker.n_drains, tracker.n_full_drains, tracker.n_clears,
             n_targets);
    $display("checked %0d list entries, %0d errors", tracker.n_entries, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[xor_closest_k_list] OK");
    end else begin
      if (tracker.pending() != 0)
        $display("%0t: %0d expected entries never arrived", $time, tracker.pending());
      $display("[xor_closest_k_list] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout with %0d entries outstanding", $time, tracker.pending());
    $display("[xor_closest_k_list] ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/xcl_pkg.sv
rtl/xcl_ram.sv
rtl/xcl_dist_cmp.sv
rtl/xor_closest_k_list.sv
bench/tb_top.sv
